/* sv/cwpg_pkg.sv */
// Package with the shared configuration width constant for the co-occurrence window pair generator.
`default_nettype none

package cwpg_pkg;

  localparam int unsigned CFG_BITS = 5;

endpackage : cwpg_pkg

`default_nettype wire

/* sv/cooccurrence_window_pair_generator_top.sv */
// Top level of the co-occurrence window pair generator with its window memory.
// The first pair of a request is loaded into the output register from ST_PAIR_A, after the slot is read into rd_q.
// Throughput: a request with n paired slots gives 2*n pairs, one pair per cycle while out_stall_i does not hold
// the output; the single read port of the window memory fetches one slot per two pairs.
// An end marker, a zero window or an empty window is taken in the idle state and gives no pair.
// Reset clears window_size, fill count, replace position and control; the memory is not cleared.
`default_nettype none

module cooccurrence_window_pair_generator_top
  import cwpg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned ID_BITS    = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_BITS-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ID_BITS-1:0]  word_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ID_BITS-1:0]       first_id_o,
  output logic [ID_BITS-1:0]       second_id_o,
  output logic                     last_pair_o
);

  localparam int unsigned IDXW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW   = (FW > CFG_BITS) ? FW : CFG_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAIR_A,
    ST_PAIR_B
  } state_e;

  state_e              state_q;
  logic [CFG_BITS-1:0] ws_q;
  logic [FW-1:0]       fill_q;
  logic [IDXW-1:0]     rep_q;
  logic [IDXW-1:0]     k_q;
  logic [ID_BITS-1:0]  id_q;
  logic [ID_BITS-1:0]  rd_q;
  logic                out_valid_q;
  logic [ID_BITS-1:0]  first_q;
  logic [ID_BITS-1:0]  second_q;
  logic                last_q;

  logic [ID_BITS-1:0] mem [MAX_WINDOW];

  logic [CW-1:0]      ws_ext;
  logic [CW-1:0]      win;
  logic [CW-1:0]      fill_ext;
  logic [CW-1:0]      used;
  logic               fill_free;
  logic [CW-1:0]      rep_pos;
  logic [CW-1:0]      rep_next;
  logic               last_k;
  logic               out_load;
  logic               in_acc;
  logic               push;
  logic               push_last;
  logic [ID_BITS-1:0] push_first;
  logic [ID_BITS-1:0] push_second;
  logic               rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic               commit;
  logic [IDXW-1:0]    wr_addr;
  logic [ID_BITS-1:0] wr_data;
  state_e             state_d;
  logic [IDXW-1:0]    k_d;

  assign ws_ext   = CW'(ws_q);
  assign win      = (ws_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : ws_ext;
  assign fill_ext = CW'(fill_q);
  assign used     = (fill_ext < win) ? fill_ext : win;
  assign fill_free = fill_ext < win;
  assign rep_pos  = (CW'(rep_q) < win) ? CW'(rep_q) : '0;
  assign rep_next = ((rep_pos + CW'(1)) >= win) ? '0 : (rep_pos + CW'(1));
  assign last_k   = (CW'(k_q) + CW'(1)) == used;
  assign wr_addr  = fill_free ? fill_q[IDXW-1:0] : rep_pos[IDXW-1:0];

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    push        = 1'b0;
    push_last   = 1'b0;
    push_first  = id_q;
    push_second = rd_q;
    rd_en       = 1'b0;
    rd_addr     = k_q;
    commit      = 1'b0;
    wr_data     = id_q;
    case (state_q)
      ST_IDLE: begin
        wr_data = word_id_i;
        if (in_acc && (word_id_i != '0) && (win != '0)) begin
          if (used == '0) begin
            commit = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            k_d     = '0;
            state_d = ST_PAIR_A;
          end
        end
      end
      ST_PAIR_A: begin
        if (out_load) begin
          push    = 1'b1;
          state_d = ST_PAIR_B;
        end
      end
      ST_PAIR_B: begin
        push_first  = rd_q;
        push_second = id_q;
        if (out_load) begin
          push      = 1'b1;
          push_last = last_k;
          if (last_k) begin
            commit  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k_q + IDXW'(1);
            k_d     = k_q + IDXW'(1);
            state_d = ST_PAIR_A;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= '0;
      fill_q      <= '0;
      rep_q       <= '0;
      k_q         <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
      first_q     <= '0;
      second_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        ws_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        id_q <= word_id_i;
        if (word_id_i == '0) begin
          fill_q <= '0;
          rep_q  <= '0;
        end
      end
      if (commit) begin
        if (fill_free) begin
          fill_q <= fill_q + FW'(1);
        end else begin
          rep_q <= rep_next[IDXW-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= push;
        first_q     <= push_first;
        second_q    <= push_second;
        last_q      <= push_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign first_id_o  = first_q;
  assign second_id_o = second_q;
  assign last_pair_o = last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(fill_q) <= CW'(MAX_WINDOW))
    else $error("fill count exceeds the window depth");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAIR_A || state_q == ST_PAIR_B) |-> (CW'(k_q) < used))
    else $error("slot index beyond the paired slots");

  a_ids_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_id_o != '0) && (second_id_o != '0))
    else $error("pair carries a sentence end id");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_load && push_last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after the last pair");

endmodule : cooccurrence_window_pair_generator_top

`default_nettype wire
